// ===== rtl/core/mtn_pkg.sv =====
// Shared types and constants for the mono-to-nibble color expansion blitter.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package mtn_pkg;

    localparam int ADDR_BITS   = 20;   // frame buffer byte address width
    localparam int COORD_BITS  = 12;   // pixel and row counter width
    localparam int PIX_PER_SRC = 8;    // pixels in one source byte
    localparam int DST_SLOTS   = 5;    // destination bytes one source byte can touch
    localparam int NIB_SLOTS   = 2 * DST_SLOTS;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int SLOT_IDX_W  = $clog2(DST_SLOTS);

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SRC_BIT_OFFSET    = 3'd0,
        REG_GLYPH_WIDTH       = 3'd1,
        REG_GLYPH_HEIGHT      = 3'd2,
        REG_DEST_X            = 3'd3,
        REG_DEST_Y            = 3'd4,
        REG_DEST_PITCH        = 3'd5,
        REG_COLOR_PAIR        = 3'd6,
        REG_BACKGROUND_ENABLE = 3'd7
    } cfg_reg_t;

    // one classified source byte: a window of up to five destination bytes
    typedef struct packed {
        logic [ADDR_BITS-1:0]     base_addr;   // address of the first byte in the window
        logic [8*DST_SLOTS-1:0]   data;        // nibble colors, low nibble first
        logic [NIB_SLOTS-1:0]     nib_en;      // painted nibbles
        logic                     glyph_end;   // this byte finished the glyph
    } mtn_entry_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        mtn_entry_t entry;
    } mtn_head_t;

endpackage

// ===== rtl/core/mono_to_nibble_color_expand.sv =====
// Mono-to-4bpp color expansion: a pushed byte is held in the queue, then its writes are registered.
// Each byte makes as many destination writes as it touches (1 to 5), one per beat,
// through the single write register of the back end; a byte that paints nothing is dropped.
// Push and pop run independently through a 4-entry queue between front and back ends.
// Reset (rst_n low, asynchronous) empties the queue, restores register defaults
// and starts a fresh glyph.
`timescale 1ns / 1ps

module mono_to_nibble_color_expand
    import mtn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            glyph_bits,
    output logic                  empty,
    input  logic                  pop,
    output logic [ADDR_BITS-1:0]  write_address,
    output logic [7:0]            write_data,
    output logic [1:0]            nibble_enable,
    output logic                  last_of_item,
    output logic                  glyph_done
);

    logic       accept;
    logic       enq;
    mtn_entry_t enq_entry;
    logic       deq;
    mtn_head_t  head;

    assign accept = push && !full;

    mtn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .glyph_bits  (glyph_bits),
        .enq         (enq),
        .enq_entry   (enq_entry)
    );

    mtn_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq       (enq),
        .enq_entry (enq_entry),
        .deq       (deq),
        .full      (full),
        .head      (head)
    );

    mtn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .deq           (deq),
        .pop           (pop),
        .empty         (empty),
        .write_address (write_address),
        .write_data    (write_data),
        .nibble_enable (nibble_enable),
        .last_of_item  (last_of_item),
        .glyph_done    (glyph_done)
    );

endmodule

// ===== rtl/core/mtn_front.sv =====
// Front end: configuration registers, glyph row/column tracking and pixel classification.
// Depends on mtn_pkg; feeds the entry queue.
`timescale 1ns / 1ps

module mtn_front
    import mtn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  accept,
    input  logic [7:0]            glyph_bits,
    output logic                  enq,
    output mtn_entry_t            enq_entry
);

    logic [2:0]            src_off_reg;
    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;
    logic [COORD_BITS-1:0] dest_x_reg;
    logic [COORD_BITS-1:0] dest_y_reg;
    logic [COORD_BITS-1:0] pitch_reg;
    logic [7:0]            color_reg;
    logic                  bg_en_reg;
    logic [ADDR_BITS-1:0]  start_base_reg;
    logic [ADDR_BITS-1:0]  start_base_next;

    logic [COORD_BITS-1:0] row_count_reg, row_count_next;
    logic [COORD_BITS-1:0] pdr_reg, pdr_next;
    logic [ADDR_BITS-1:0]  row_base_reg, row_base_next;
    logic                  first_reg, first_next;

    logic [COORD_BITS-1:0] width_eff;
    logic [COORD_BITS-1:0] height_eff;
    logic                  glyph_start;
    logic [ADDR_BITS-1:0]  base_eff;
    logic [2:0]            start_bit;
    logic [3:0]            avail;
    logic [COORD_BITS-1:0] remain;
    logic [3:0]            count;
    logic [COORD_BITS:0]   col0;
    logic [ADDR_BITS-1:0]  first_addr;
    logic [PIX_PER_SRC-1:0]   pix_en;
    logic [4*PIX_PER_SRC-1:0] pix_data;
    logic [NIB_SLOTS-1:0]     win_en;
    logic [8*DST_SLOTS-1:0]   win_data;
    logic [COORD_BITS-1:0] pdr_sum;
    logic                  row_end;
    logic [COORD_BITS-1:0] row_inc;
    logic                  glyph_end;

    // recompute the glyph start base whenever dest_y or pitch is written
    always_comb
    begin
        start_base_next = start_base_reg;
        if (cfg_write)
        begin
            if (cfg_reg_t'(cfg_index) == REG_DEST_Y)
                start_base_next = ADDR_BITS'(cfg_data) * ADDR_BITS'(pitch_reg);
            else if (cfg_reg_t'(cfg_index) == REG_DEST_PITCH)
                start_base_next = ADDR_BITS'(dest_y_reg) * ADDR_BITS'(cfg_data);
        end
    end

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_off_reg    <= '0;
            width_reg      <= COORD_BITS'(1);
            height_reg     <= COORD_BITS'(1);
            dest_x_reg     <= '0;
            dest_y_reg     <= '0;
            pitch_reg      <= COORD_BITS'(1);
            color_reg      <= 8'h0f;
            bg_en_reg      <= 1'b0;
            start_base_reg <= '0;
        end
        else
        begin
            start_base_reg <= start_base_next;
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SRC_BIT_OFFSET:    src_off_reg <= cfg_data[2:0];
                    REG_GLYPH_WIDTH:       width_reg   <= cfg_data;
                    REG_GLYPH_HEIGHT:      height_reg  <= cfg_data;
                    REG_DEST_X:            dest_x_reg  <= cfg_data;
                    REG_DEST_Y:            dest_y_reg  <= cfg_data;
                    REG_DEST_PITCH:        pitch_reg   <= cfg_data;
                    REG_COLOR_PAIR:        color_reg   <= cfg_data[7:0];
                    REG_BACKGROUND_ENABLE: bg_en_reg   <= cfg_data[0];
                endcase
            end
        end
    end

    // size the span of this byte within the row
    always_comb
    begin
        width_eff   = (width_reg == '0) ? COORD_BITS'(1) : width_reg;
        height_eff  = (height_reg == '0) ? COORD_BITS'(1) : height_reg;
        glyph_start = (row_count_reg == '0) && (pdr_reg == '0);
        base_eff    = glyph_start ? start_base_reg : row_base_reg;
        start_bit   = first_reg ? src_off_reg : 3'd0;
        avail       = 4'd8 - {1'b0, start_bit};
        remain      = (pdr_reg < width_eff) ? (width_eff - pdr_reg) : COORD_BITS'(1);
        count       = (COORD_BITS'(avail) < remain) ? avail : remain[3:0];
        col0        = {1'b0, dest_x_reg} + {1'b0, pdr_reg};
        first_addr  = base_eff + ADDR_BITS'(col0 >> 1);
    end

    // classify each pixel: paint with foreground, background or skip
    always_comb
    begin
        logic [3:0] bit_pos;
        logic       used;
        logic       set;
        pix_en   = '0;
        pix_data = '0;
        for (int i = 0; i < PIX_PER_SRC; i++)
        begin
            bit_pos = {1'b0, start_bit} + 4'(i);
            used    = 4'(i) < count;
            set     = glyph_bits[3'(4'd7 - bit_pos)];
            if (used && (set || bg_en_reg))
            begin
                pix_en[i]         = 1'b1;
                pix_data[4*i +: 4] = set ? color_reg[3:0] : color_reg[7:4];
            end
        end
        // align to the destination byte window by column parity
        if (col0[0])
        begin
            win_en   = {1'b0, pix_en, 1'b0};
            win_data = {4'h0, pix_data, 4'h0};
        end
        else
        begin
            win_en   = {2'b00, pix_en};
            win_data = {8'h00, pix_data};
        end
    end

    // advance column, row and row base
    always_comb
    begin
        pdr_sum        = pdr_reg + COORD_BITS'(count);
        row_end        = pdr_sum >= width_eff;
        row_inc        = row_count_reg + COORD_BITS'(1);
        glyph_end      = row_end && (row_inc >= height_eff);
        first_next     = row_end;
        pdr_next       = row_end ? '0 : pdr_sum;
        row_base_next  = row_end ? (base_eff + ADDR_BITS'(pitch_reg)) : base_eff;
        row_count_next = row_end ? (glyph_end ? '0 : row_inc) : row_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            pdr_reg       <= '0;
            row_base_reg  <= '0;
            first_reg     <= 1'b1;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            pdr_reg       <= pdr_next;
            row_base_reg  <= row_base_next;
            first_reg     <= first_next;
        end
    end

    // drop bytes that paint nothing
    assign enq                 = accept && (win_en != '0);
    assign enq_entry.base_addr = first_addr;
    assign enq_entry.data      = win_data;
    assign enq_entry.nib_en    = win_en;
    assign enq_entry.glyph_end = glyph_end;

endmodule

// ===== rtl/core/mtn_fifo.sv =====
// Short entry queue between the front end and the write generator.
// Depends on mtn_pkg.
`timescale 1ns / 1ps

module mtn_fifo
    import mtn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       enq,
    input  mtn_entry_t enq_entry,
    input  logic       deq,
    output logic       full,
    output mtn_head_t  head
);

    mtn_entry_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full       = count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = entry_reg[rd_ptr_reg];

    // advance pointers and occupancy
    always_comb
    begin
        do_wr       = enq && !full;
        do_rd       = deq && head.valid;
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_PTR_W+1)'(do_wr) - (FIFO_PTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= enq_entry;
    end

endmodule

// ===== rtl/core/mtn_back.sv =====
// Back end: walks the queue head's destination bytes and registers one write per beat.
// Depends on mtn_pkg; drains mtn_fifo.
`timescale 1ns / 1ps

module mtn_back
    import mtn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtn_head_t            head,
    output logic                 deq,
    input  logic                 pop,
    output logic                 empty,
    output logic [ADDR_BITS-1:0] write_address,
    output logic [7:0]           write_data,
    output logic [1:0]           nibble_enable,
    output logic                 last_of_item,
    output logic                 glyph_done
);

    logic [DST_SLOTS-1:0]  rem_reg, rem_next;
    logic                  started_reg, started_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [7:0]            data_reg;
    logic [1:0]            en_reg;
    logic                  last_reg;
    logic                  done_reg;

    logic [DST_SLOTS-1:0]  slot_mask;
    logic [DST_SLOTS-1:0]  pending;
    logic [DST_SLOTS-1:0]  lowest;
    logic [DST_SLOTS-1:0]  rest;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  load;

    // pick the lowest destination byte still to write
    always_comb
    begin
        for (int j = 0; j < DST_SLOTS; j++)
            slot_mask[j] = |head.entry.nib_en[2*j +: 2];
        pending = started_reg ? rem_reg : slot_mask;
        lowest  = pending & (~pending + 1'b1);
        rest    = pending & ~lowest;
        idx     = '0;
        for (int j = 0; j < DST_SLOTS; j++)
        begin
            if (lowest[j])
                idx = SLOT_IDX_W'(j);
        end
    end

    assign load = head.valid && (!out_valid_reg || pop);
    assign deq  = load && (rest == '0);

    always_comb
    begin
        rem_next       = rem_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            rem_next       = rest;
            started_next   = rest != '0;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // register the write beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= head.entry.base_addr + ADDR_BITS'(idx);
            data_reg <= head.entry.data[8*idx +: 8];
            en_reg   <= head.entry.nib_en[2*idx +: 2];
            last_reg <= rest == '0;
            done_reg <= (rest == '0) && head.entry.glyph_end;
        end
    end

    assign empty         = !out_valid_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign nibble_enable = en_reg;
    assign last_of_item  = last_reg;
    assign glyph_done    = done_reg;

endmodule

// ===== rtl/core/mtn_checker.sv =====
// Port-level checks for mono_to_nibble_color_expand, attached by bind.
// Depends on mtn_pkg.
`timescale 1ns / 1ps

module mtn_checker
    import mtn_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input logic [ADDR_BITS-1:0]  write_address,
    input logic [7:0]            write_data,
    input logic [1:0]            nibble_enable,
    input logic                  last_of_item,
    input logic                  glyph_done
);

    // glyph end only on the final beat of a byte
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && glyph_done) |-> last_of_item)
        else $error("glyph_done without last_of_item");

    // no empty writes
    a_some_enable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (nibble_enable != 2'b00))
        else $error("write beat with no nibble enabled");

    // disabled nibbles carry zero
    a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((nibble_enable[0] || write_data[3:0] == 4'h0) &&
                    (nibble_enable[1] || write_data[7:4] == 4'h0)))
        else $error("disabled nibble holds nonzero data");

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(write_address) && $stable(write_data)
                              && $stable(nibble_enable) && $stable(last_of_item)))
        else $error("stalled write beat changed");

endmodule

bind mono_to_nibble_color_expand mtn_checker u_mtn_checker (.*);
